// File: sv/depq_pkg.sv
// Package for the double-ended priority queue core.
// Holds opcodes, status codes, sequencer states, cell actions and fixed field widths.
// No dependencies.
package depq_pkg;

  localparam int OP_W        = 3;
  localparam int ITEM_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 16;
  localparam int TOTAL_OUT_W = 22;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 176;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_ERASE   = 3'd1,
    OP_POP_MIN = 3'd2,
    OP_POP_MAX = 3'd3,
    OP_COUNT   = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_SATURATED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INC_HIT,
    CELL_INSERT,
    CELL_DEC_HIT,
    CELL_REMOVE_HIT,
    CELL_DEC_FIRST,
    CELL_SHIFT_DOWN,
    CELL_DEC_LAST
  } cell_act_t;

endpackage

// File: sv/double_ended_priority_queue_core.sv
// Top level of the double-ended priority queue: stream ports, sequencer and the cell chain.
// Depends on depq_pkg and depq_cell.
//
// A sorted multiset kept in a row of DISTINCT_ENTRIES cells, one distinct value and its count
// per cell, in ascending signed order. Each request passes through state EXEC, in which
// every cell compares its value with the request value and the row inserts, removes or
// adjusts a count in one shift, and then state REPORT, in which the row is read back to form
// the result and load it into the output register once that register is free. A new request
// is accepted in the cycle the previous result is loaded into the output register, so the
// core takes a new request while its previous result waits on the master side. Storage needs
// no clearing pass after reset; only the fill count and the total are reset.
module double_ended_priority_queue_core #(
  parameter int DISTINCT_ENTRIES = 64,
  parameter int VALUE_BITS       = 32,
  parameter int COUNT_BITS       = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // op [2:0], item_value [34:3], zero [39:35]
  input  logic [depq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status [2:0], popped_value [34:3], value_count [50:35], min_value [82:51],
  // max_value [114:83], min_count [130:115], max_count [146:131],
  // total_size [168:147], is_empty [169], zero [175:170]
  output logic [depq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int USED_BITS  = $clog2(DISTINCT_ENTRIES + 1);
  localparam int TOTAL_BITS = USED_BITS + COUNT_BITS;
  localparam int IW         = depq_pkg::ITEM_W;
  localparam int CW         = depq_pkg::COUNT_OUT_W;
  localparam logic [USED_BITS-1:0]  FULL_USED = USED_BITS'(DISTINCT_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  depq_pkg::state_t     state, state_next;
  depq_pkg::op_t        op;
  depq_pkg::cell_act_t  act;
  depq_pkg::status_t    status, status_next;
  logic [VALUE_BITS-1:0] key;
  logic [VALUE_BITS-1:0] popped, popped_next;
  logic [USED_BITS-1:0]  used, used_next;
  logic [TOTAL_BITS-1:0] total, total_next;
  logic                  out_valid;
  logic [depq_pkg::OUT_DATA_W-1:0] out_data;
  logic                  out_free;
  logic                  load_out;
  logic                  take_in;

  logic [VALUE_BITS-1:0] cell_value [DISTINCT_ENTRIES];
  logic [COUNT_BITS-1:0] cell_count [DISTINCT_ENTRIES];
  logic [DISTINCT_ENTRIES-1:0] cell_occ, cell_lt, cell_eq, cell_last;

  logic                  found;
  logic [COUNT_BITS-1:0] hit_count, last_count;
  logic [VALUE_BITS-1:0] last_value;
  logic                  is_empty;
  logic [IW-1:0]         min_out;
  logic [CW-1:0]         min_count_out;

  genvar gi;
  generate
    for (gi = 0; gi < DISTINCT_ENTRIES; gi++) begin : g_cell
      logic [VALUE_BITS-1:0] lv, rv;
      logic [COUNT_BITS-1:0] lc, rc;
      logic                  llt;
      if (gi == 0) begin : g_first
        assign lv  = '0;
        assign lc  = '0;
        assign llt = 1'b1;
      end else begin : g_mid
        assign lv  = cell_value[gi-1];
        assign lc  = cell_count[gi-1];
        assign llt = cell_lt[gi-1];
      end
      if (gi == DISTINCT_ENTRIES - 1) begin : g_end
        assign rv = '0;
        assign rc = '0;
      end else begin : g_inner
        assign rv = cell_value[gi+1];
        assign rc = cell_count[gi+1];
      end
      depq_cell #(
        .IDX        (gi),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .USED_BITS  (USED_BITS)
      ) u_cell (
        .clk         (clk),
        .act         (act),
        .key         (key),
        .used        (used),
        .left_value  (lv),
        .left_count  (lc),
        .left_lt     (llt),
        .right_value (rv),
        .right_count (rc),
        .value       (cell_value[gi]),
        .count       (cell_count[gi]),
        .occ         (cell_occ[gi]),
        .lt          (cell_lt[gi]),
        .eq          (cell_eq[gi]),
        .last        (cell_last[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_count  = '0;
    last_count = '0;
    last_value = '0;
    for (int i = 0; i < DISTINCT_ENTRIES; i++) begin
      hit_count  = hit_count  | (cell_eq[i]   ? cell_count[i] : '0);
      last_count = last_count | (cell_last[i] ? cell_count[i] : '0);
      last_value = last_value | (cell_last[i] ? cell_value[i] : '0);
    end
  end

  assign found    = |cell_eq;
  assign is_empty = (used == '0);
  assign out_free = !out_valid || m_axis_tready;
  assign take_in  = s_axis_tvalid && s_axis_tready;

  assign min_out       = cell_occ[0] ? IW'($signed(cell_value[0])) : '0;
  assign min_count_out = cell_occ[0] ? CW'(cell_count[0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= depq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    act           = depq_pkg::CELL_HOLD;
    used_next     = used;
    total_next    = total;
    status_next   = depq_pkg::STAT_OK;
    popped_next   = '0;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      depq_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        if (s_axis_tvalid) begin
          state_next = depq_pkg::ST_EXEC;
        end
      end
      depq_pkg::ST_EXEC: begin
        state_next = depq_pkg::ST_REPORT;
        unique case (op)
          depq_pkg::OP_PUSH: begin
            if (found) begin
              if (hit_count == COUNT_TOP) begin
                status_next = depq_pkg::STAT_SATURATED;
              end else begin
                act        = depq_pkg::CELL_INC_HIT;
                total_next = total + TOTAL_BITS'(1);
              end
            end else if (used == FULL_USED) begin
              status_next = depq_pkg::STAT_FULL;
            end else begin
              act        = depq_pkg::CELL_INSERT;
              used_next  = used + USED_BITS'(1);
              total_next = total + TOTAL_BITS'(1);
            end
          end
          depq_pkg::OP_ERASE: begin
            if (found) begin
              if (hit_count == COUNT_ONE) begin
                act       = depq_pkg::CELL_REMOVE_HIT;
                used_next = used - USED_BITS'(1);
              end else begin
                act = depq_pkg::CELL_DEC_HIT;
              end
              if (total != '0) begin
                total_next = total - TOTAL_BITS'(1);
              end
            end else begin
              status_next = depq_pkg::STAT_NOT_FOUND;
            end
          end
          depq_pkg::OP_POP_MIN: begin
            if (is_empty) begin
              status_next = depq_pkg::STAT_EMPTY;
            end else begin
              popped_next = cell_value[0];
              if (cell_count[0] == COUNT_ONE) begin
                act       = depq_pkg::CELL_SHIFT_DOWN;
                used_next = used - USED_BITS'(1);
              end else begin
                act = depq_pkg::CELL_DEC_FIRST;
              end
              if (total != '0) begin
                total_next = total - TOTAL_BITS'(1);
              end
            end
          end
          depq_pkg::OP_POP_MAX: begin
            if (is_empty) begin
              status_next = depq_pkg::STAT_EMPTY;
            end else begin
              popped_next = last_value;
              if (last_count == COUNT_ONE) begin
                used_next = used - USED_BITS'(1);
              end else begin
                act = depq_pkg::CELL_DEC_LAST;
              end
              if (total != '0) begin
                total_next = total - TOTAL_BITS'(1);
              end
            end
          end
          depq_pkg::OP_CLEAR: begin
            used_next  = '0;
            total_next = '0;
          end
          default: begin
          end
        endcase
      end
      depq_pkg::ST_REPORT: begin
        if (out_free) begin
          load_out      = 1'b1;
          s_axis_tready = 1'b1;
          state_next    = s_axis_tvalid ? depq_pkg::ST_EXEC : depq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = depq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      total <= '0;
    end else begin
      used  <= used_next;
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      op  <= depq_pkg::op_t'(s_axis_tdata[2:0]);
      key <= VALUE_BITS'(s_axis_tdata[IW+2:3]);
    end
    if (state == depq_pkg::ST_EXEC) begin
      status <= status_next;
      popped <= popped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {
        6'd0,
        is_empty,
        depq_pkg::TOTAL_OUT_W'(total),
        CW'(last_count),
        min_count_out,
        IW'($signed(last_value)),
        min_out,
        CW'(hit_count),
        IW'($signed(popped)),
        status
      };
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// File: sv/depq_cell.sv
// One cell of the sorted chain: holds a distinct value and its occurrence count.
// Compares against the broadcast key and shifts with its neighbors on command.
// Depends on depq_pkg.
module depq_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16,
  parameter int USED_BITS  = 7
) (
  input  logic                    clk,
  input  depq_pkg::cell_act_t     act,
  input  logic [VALUE_BITS-1:0]   key,
  input  logic [USED_BITS-1:0]    used,
  input  logic [VALUE_BITS-1:0]   left_value,
  input  logic [COUNT_BITS-1:0]   left_count,
  input  logic                    left_lt,
  input  logic [VALUE_BITS-1:0]   right_value,
  input  logic [COUNT_BITS-1:0]   right_count,
  output logic [VALUE_BITS-1:0]   value,
  output logic [COUNT_BITS-1:0]   count,
  output logic                    occ,
  output logic                    lt,
  output logic                    eq,
  output logic                    last
);

  localparam logic [USED_BITS-1:0] MY_IDX  = USED_BITS'(IDX);
  localparam logic [USED_BITS-1:0] MY_NEXT = USED_BITS'(IDX + 1);

  assign occ  = MY_IDX < used;
  assign lt   = occ && ($signed(value) < $signed(key));
  assign eq   = occ && (value == key);
  assign last = (MY_NEXT == used);

  always_ff @(posedge clk) begin
    unique case (act)
      depq_pkg::CELL_HOLD: begin
      end
      depq_pkg::CELL_INC_HIT: begin
        if (eq) begin
          count <= count + COUNT_BITS'(1);
        end
      end
      depq_pkg::CELL_INSERT: begin
        if (!lt) begin
          if (left_lt) begin
            value <= key;
            count <= COUNT_BITS'(1);
          end else begin
            value <= left_value;
            count <= left_count;
          end
        end
      end
      depq_pkg::CELL_DEC_HIT: begin
        if (eq) begin
          count <= count - COUNT_BITS'(1);
        end
      end
      depq_pkg::CELL_REMOVE_HIT: begin
        if (!lt) begin
          value <= right_value;
          count <= right_count;
        end
      end
      depq_pkg::CELL_DEC_FIRST: begin
        if (IDX == 0) begin
          count <= count - COUNT_BITS'(1);
        end
      end
      depq_pkg::CELL_SHIFT_DOWN: begin
        value <= right_value;
        count <= right_count;
      end
      depq_pkg::CELL_DEC_LAST: begin
        if (last) begin
          count <= count - COUNT_BITS'(1);
        end
      end
    endcase
  end

endmodule

// File: bench/depq_checker.sv
// Result checker for double_ended_priority_queue_core: predicts every request and compares results.
// Depends on depq_pkg; watches both stream channels and reports a running failure count.
module depq_checker
  import depq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen,
  output int                    full_seen,
  output int                    saturated_seen,
  output int                    not_found_seen,
  output int                    empty_seen
);

  localparam int          SLOTS      = 64;
  localparam logic [15:0] COUNT_CEIL = 16'hFFFF;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ITEM_W-1:0]      popped;
    logic [COUNT_OUT_W-1:0] value_count;
    logic [ITEM_W-1:0]      min_value;
    logic [ITEM_W-1:0]      max_value;
    logic [COUNT_OUT_W-1:0] min_count;
    logic [COUNT_OUT_W-1:0] max_count;
    logic [TOTAL_OUT_W-1:0] total_size;
    logic                   is_empty;
  } depq_result_t;

  logic signed [ITEM_W-1:0]  slot_value [SLOTS];
  logic [COUNT_OUT_W-1:0]    slot_count [SLOTS];
  int                        slots_used = 0;
  logic [TOTAL_OUT_W-1:0]    occupancy = '0;
  depq_result_t              expected_results [$];
  int                        fail_tally = 0;
  int                        result_tally = 0;
  int                        full_tally = 0;
  int                        saturated_tally = 0;
  int                        not_found_tally = 0;
  int                        empty_tally = 0;

  function automatic int first_not_below(logic signed [ITEM_W-1:0] v);
    int i;
    i = 0;
    while (i < slots_used && slot_value[i] < v) i++;
    return i;
  endfunction

  function automatic bit holds_at(int i, logic signed [ITEM_W-1:0] v);
    return i < slots_used && slot_value[i] == v;
  endfunction

  function automatic void drop_one(int i);
    int j;
    slot_count[i] = slot_count[i] - 1'b1;
    if (slot_count[i] == 0) begin
      for (j = i; j + 1 < slots_used; j++) begin
        slot_value[j] = slot_value[j + 1];
        slot_count[j] = slot_count[j + 1];
      end
      slots_used--;
    end
    if (occupancy != 0) occupancy = occupancy - 1'b1;
  endfunction

  function automatic string format_result(depq_result_t r);
    return $sformatf("status %0d popped %h count %0d min %h/%0d max %h/%0d total %0d empty %0b",
                     r.status, r.popped, r.value_count, r.min_value, r.min_count,
                     r.max_value, r.max_count, r.total_size, r.is_empty);
  endfunction

  task automatic execute_request(input logic [OP_W-1:0] op,
                                 input logic signed [ITEM_W-1:0] v,
                                 output depq_result_t r);
    int                pos;
    int                j;
    status_t           st;
    logic [ITEM_W-1:0] popped;
    st     = STAT_OK;
    popped = '0;
    case (op)
      OP_PUSH: begin
        pos = first_not_below(v);
        if (holds_at(pos, v)) begin
          if (slot_count[pos] == COUNT_CEIL) begin
            st = STAT_SATURATED;
          end else begin
            slot_count[pos] = slot_count[pos] + 1'b1;
            occupancy = occupancy + 1'b1;
          end
        end else if (slots_used >= SLOTS) begin
          st = STAT_FULL;
        end else begin
          for (j = slots_used; j > pos; j--) begin
            slot_value[j] = slot_value[j - 1];
            slot_count[j] = slot_count[j - 1];
          end
          slot_value[pos] = v;
          slot_count[pos] = 1;
          slots_used++;
          occupancy = occupancy + 1'b1;
        end
      end
      OP_ERASE: begin
        pos = first_not_below(v);
        if (holds_at(pos, v)) drop_one(pos);
        else st = STAT_NOT_FOUND;
      end
      OP_POP_MIN, OP_POP_MAX: begin
        if (slots_used == 0) begin
          st = STAT_EMPTY;
        end else begin
          pos = (op == OP_POP_MIN) ? 0 : slots_used - 1;
          popped = slot_value[pos];
          drop_one(pos);
        end
      end
      OP_CLEAR: begin
        slots_used = 0;
        occupancy  = '0;
      end
      default: ;
    endcase

    pos = first_not_below(v);
    r.status      = st;
    r.popped      = popped;
    r.value_count = holds_at(pos, v) ? slot_count[pos] : '0;
    if (slots_used == 0) begin
      r.min_value = '0;
      r.max_value = '0;
      r.min_count = '0;
      r.max_count = '0;
      r.is_empty  = 1'b1;
    end else begin
      r.min_value = slot_value[0];
      r.max_value = slot_value[slots_used - 1];
      r.min_count = slot_count[0];
      r.max_count = slot_count[slots_used - 1];
      r.is_empty  = 1'b0;
    end
    r.total_size = occupancy;
  endtask

  always @(posedge clk) begin : watch
    depq_result_t prediction;
    depq_result_t observed;
    if (rst) begin
      slots_used = 0;
      occupancy  = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        execute_request(s_axis_tdata[OP_W-1:0], s_axis_tdata[OP_W +: ITEM_W], prediction);
        expected_results.push_back(prediction);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        observed.status      = m_axis_tdata[2:0];
        observed.popped      = m_axis_tdata[34:3];
        observed.value_count = m_axis_tdata[50:35];
        observed.min_value   = m_axis_tdata[82:51];
        observed.max_value   = m_axis_tdata[114:83];
        observed.min_count   = m_axis_tdata[130:115];
        observed.max_count   = m_axis_tdata[146:131];
        observed.total_size  = m_axis_tdata[168:147];
        observed.is_empty    = m_axis_tdata[169];
        result_tally++;
        case (observed.status)
          STAT_FULL:      full_tally++;
          STAT_SATURATED: saturated_tally++;
          STAT_NOT_FOUND: not_found_tally++;
          STAT_EMPTY:     empty_tally++;
          default: ;
        endcase
        if (expected_results.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("result %0d with nothing pending: %s", result_tally,
                     format_result(observed));
        end else begin
          prediction = expected_results.pop_front();
          if (observed !== prediction) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("result %0d expected %s", result_tally, format_result(prediction));
              $display("result %0d actual   %s", result_tally, format_result(observed));
            end
          end
        end
      end
    end
    mismatches     <= fail_tally;
    outstanding    <= expected_results.size();
    results_seen   <= result_tally;
    full_seen      <= full_tally;
    saturated_seen <= saturated_tally;
    not_found_seen <= not_found_tally;
    empty_seen     <= empty_tally;
  end

endmodule

// File: bench/testbench.sv
// Top of the bench for double_ended_priority_queue_core: clock, reset, requests and verdict.
// Depends on depq_pkg, the core and depq_checker, which does all prediction and comparison.
module testbench;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int POOL_SIZE    = 48;
  localparam logic [depq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [depq_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [depq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [depq_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int full_seen;
  int saturated_seen;
  int not_found_seen;
  int empty_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;
  int cycles = 0;
  logic [depq_pkg::ITEM_W-1:0] value_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_priority_queue_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  depq_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .full_seen      (full_seen),
    .saturated_seen (saturated_seen),
    .not_found_seen (not_found_seen),
    .empty_seen     (empty_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
      $display("double_ended_priority_queue_core: mismatch");
      $finish;
    end
  end

  // Hold the output off once for a long stretch so the core backs up into its input.
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0 && held < hold_off_cycles) begin
        m_axis_tready <= 1'b0;
        held++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_request(input logic [depq_pkg::OP_W-1:0] op,
                              input logic [depq_pkg::ITEM_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(depq_pkg::IN_DATA_W - depq_pkg::OP_W - depq_pkg::ITEM_W){1'b0}},
                      value, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random_request();
    int                          pick;
    logic [depq_pkg::OP_W-1:0]   op;
    logic [depq_pkg::ITEM_W-1:0] value;
    pick = $urandom_range(99);
    if (pick < 45)      op = depq_pkg::OP_PUSH;
    else if (pick < 60) op = depq_pkg::OP_ERASE;
    else if (pick < 68) op = depq_pkg::OP_POP_MIN;
    else if (pick < 76) op = depq_pkg::OP_POP_MAX;
    else if (pick < 90) op = depq_pkg::OP_COUNT;
    else if (pick < 93) op = depq_pkg::OP_CLEAR;
    else if (pick < 97) op = OP_SPARE_LO;
    else                op = OP_SPARE_HI;
    if ($urandom_range(3) == 0) value = $urandom();
    else value = value_pool[$urandom_range(POOL_SIZE - 1)];
    send_request(op, value);
  endtask

  initial begin : stimulus
    int                          i;
    int                          phase;
    logic [5:0]                  slot_tag;
    logic [depq_pkg::ITEM_W-1:0] upper;
    logic [depq_pkg::ITEM_W-1:0] kept_value;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (i = 4; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) value_pool[i] = $urandom_range(40) - 20;
      else value_pool[i] = $urandom();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(depq_pkg::OP_POP_MIN, 32'h0000_0000);
    send_request(depq_pkg::OP_POP_MAX, 32'hFFFF_FFFF);
    send_request(depq_pkg::OP_ERASE, 32'h0000_0000);
    send_request(depq_pkg::OP_COUNT, 32'hFFFF_FFFF);
    send_request(depq_pkg::OP_PUSH, 32'h8000_0000);
    send_request(depq_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_request(depq_pkg::OP_PUSH, 32'h0000_0000);
    send_request(depq_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(depq_pkg::OP_PUSH, 32'h0000_0000);
    send_request(depq_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_request(depq_pkg::OP_COUNT, 32'h0000_0000);
    send_request(OP_SPARE_LO, 32'h0000_0000);
    send_request(OP_SPARE_HI, 32'h7FFF_FFFF);
    send_request(depq_pkg::OP_ERASE, 32'h0000_0000);
    send_request(depq_pkg::OP_ERASE, 32'h0000_0000);
    send_request(depq_pkg::OP_ERASE, 32'h0000_0000);
    send_request(depq_pkg::OP_POP_MIN, 32'h8000_0000);
    send_request(depq_pkg::OP_POP_MAX, 32'h7FFF_FFFF);
    send_request(depq_pkg::OP_POP_MAX, 32'h7FFF_FFFF);
    send_request(depq_pkg::OP_POP_MIN, 32'hFFFF_FFFF);
    send_request(depq_pkg::OP_POP_MIN, 32'h0000_0005);
    send_request(depq_pkg::OP_PUSH, 32'h0000_0005);
    send_request(depq_pkg::OP_PUSH, 32'h0000_0005);
    send_request(depq_pkg::OP_CLEAR, 32'h0000_0005);
    send_request(depq_pkg::OP_POP_MAX, 32'h0000_0001);

    // Fill every distinct slot, then push a value that is not stored.
    for (i = 0; i < 64; i++) begin
      upper      = $urandom();
      slot_tag   = 6'((i * 37) % 64);
      kept_value = {upper[31:7], 1'b0, slot_tag};
      send_request(depq_pkg::OP_PUSH, kept_value);
    end
    upper = $urandom();
    send_request(depq_pkg::OP_PUSH, {upper[31:7], 1'b1, upper[5:0]});
    send_request(depq_pkg::OP_PUSH, kept_value);
    send_request(depq_pkg::OP_ERASE, {upper[31:7], 1'b1, upper[5:0]});
    send_request(depq_pkg::OP_POP_MIN, upper);
    send_request(depq_pkg::OP_POP_MAX, upper);
    send_request(depq_pkg::OP_PUSH, {upper[31:7], 1'b1, upper[5:0]});
    send_request(depq_pkg::OP_PUSH, {~upper[31:7], 1'b1, upper[5:0]});
    send_request(depq_pkg::OP_CLEAR, upper);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct   = 0;
          stall_pct       = 0;
          hold_off_cycles = 300;
        end
        1: begin
          send_idle_pct = 76;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 76;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct     = 37;
        end
      endcase
      repeat (75) send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d results checked over directed edge values, a full table and random requests",
             results_seen);
    $display("statuses seen: %0d full, %0d saturated, %0d not found, %0d empty pop",
             full_seen, saturated_seen, not_found_seen, empty_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("double_ended_priority_queue_core: match");
    end else begin
      $display("%0d failures", mismatches);
      $display("double_ended_priority_queue_core: mismatch");
    end
    $finish;
  end

endmodule
